@@ hdl/kfht_pkg.sv @@
// Package: shared types, constants and hash helpers for the key frequency hash table.
package kfht_pkg;

    localparam int unsigned NumBucketsDef = 256;
    localparam int unsigned WaysDef       = 8;
    localparam logic [31:0] HashMul       = 32'h045d9f3b;
    localparam int unsigned HashShift     = 16;
    localparam logic [8:0]  BucketCountRst = 9'd256;

    localparam logic       CmdInsert = 1'b0;
    localparam logic       CmdLookup = 1'b1;
    localparam logic [0:0] RegBucketCount = 1'b0;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_mix1,
        t_st_mul1,
        t_st_mix2,
        t_st_mul2,
        t_st_fin,
        t_st_mod,
        t_st_fill,
        t_st_rd,
        t_st_cmp,
        t_st_upd,
        t_st_out,
        t_st_clr
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_mod_ctl;

    function automatic logic [31:0] xs16(input logic [31:0] x);
        xs16 = x ^ (x >> HashShift);
    endfunction

endpackage

@@ hdl/kfht_if.sv @@
// Interfaces: valid/ready channels for the input and result words.
interface kfht_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] key;
    logic [31:0] data_value;
    modport source (output valid, command, key, data_value, input ready);
    modport sink   (input valid, command, key, data_value, output ready);
endinterface

interface kfht_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] data_out;
    logic [31:0] count_out;
    logic        bucket_full;
    logic [11:0] unique_keys;
    logic [8:0]  buckets_used;
    modport source (output valid, found, data_out, count_out, bucket_full, unique_keys,
                    buckets_used, input ready);
    modport sink   (input valid, found, data_out, count_out, bucket_full, unique_keys,
                    buckets_used, output ready);
endinterface

@@ hdl/kfht_mod.sv @@
// Restoring divider remainder: one quotient bit per cycle, 32 steps.
module kfht_mod import kfht_pkg::*; #(
    parameter int unsigned DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [DW-1:0] i_div,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    logic [31:0] r_num, n_num;
    logic [DW:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [DW:0] w_sh;

    always_comb begin
        w_sh   = {r_rem[DW-1:0], r_num[31]};
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_sh >= {1'b0, i_div}) ? w_sh - {1'b0, i_div} : w_sh;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && r_cnt == 6'd31;
    assign o_rem  = n_rem[DW-1:0];
endmodule

@@ hdl/kfht_store.sv @@
// Entry store: key, data and count memories with registered reads.
module kfht_store import kfht_pkg::*; #(
    parameter int unsigned AW = 11
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    input  logic          i_we,
    input  logic          i_we_new,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wkey,
    input  logic [31:0]   i_wdata,
    input  logic [31:0]   i_wcount,
    output logic [31:0]   o_key,
    output logic [31:0]   o_data,
    output logic [31:0]   o_count
);
    logic [31:0] r_key_mem   [2**AW];
    logic [31:0] r_data_mem  [2**AW];
    logic [31:0] r_count_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_count_mem[i_waddr] <= i_wcount;
        end
        if (i_we_new) begin
            r_key_mem[i_waddr]  <= i_wkey;
            r_data_mem[i_waddr] <= i_wdata;
        end
        o_key   <= r_key_mem[i_raddr];
        o_data  <= r_data_mem[i_raddr];
        o_count <= r_count_mem[i_raddr];
    end
endmodule

@@ hdl/key_frequency_hash_table.sv @@
// Top level: key frequency hash table with sequencer, shared multiplier and divider.
// Usage:
//   Input channel carries command (0 insert, 1 lookup), key and data_value.
//   Result channel returns one word per input word: found, data_out,
//   count_out, bucket_full, unique_keys and buckets_used.
//   APB port: register 0 at address 0 is bucket_count (9 bits, reset 256).
// Timing:
//   One word at a time. Hashing uses one 32x32 multiplier twice, the bucket
//   remainder a bit-serial divider; then come the fill read and one read and
//   compare per way, up to the bucket's fill or a match, then write-back.
//   The divider takes the largest share of the time per word.
// Reset:
//   Synchronous, active low. Key and bucket totals clear at once; a pass over
//   all NUM_BUCKETS buckets then clears the fill counters, input not ready
//   meanwhile. Entry memory words are used only below a bucket's fill.
// Stall:
//   The result is held in an output register until taken; the next input
//   word is accepted only after the result has been taken.
module key_frequency_hash_table import kfht_pkg::*; #(
    parameter int unsigned NUM_BUCKETS = NumBucketsDef,
    parameter int unsigned WAYS        = WaysDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfht_in_if.sink     in_ch,
    kfht_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned FW = $clog2(WAYS + 1);
    localparam int unsigned AW = BW + WW;
    localparam int unsigned NW = $clog2(NUM_BUCKETS + 1);

    t_state r_state, n_state;
    logic [8:0]  r_bcnt;
    logic        r_cmd;
    logic [31:0] r_key, r_dat, r_x;
    logic [BW-1:0] r_bkt;
    logic [BW-1:0] r_clr;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_way;
    logic        r_hit;
    logic [WW-1:0] r_hway;
    logic [FW-1:0] r_fill_mem [NUM_BUCKETS];
    logic [11:0] r_uniq;
    logic [8:0]  r_used;
    logic        r_ovalid;
    logic        r_found, r_full;
    logic [31:0] r_dout, r_cout;
    t_mod_ctl    w_mod;
    logic [NW-1:0] w_div;
    logic [NW-1:0] w_rem;
    logic [31:0] w_prod;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [31:0] w_key, w_data, w_count, w_newcnt;
    logic        w_we, w_we_new, w_match;
    logic        w_in_acc, w_cfg_wr;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == RegBucketCount) ? {23'd0, r_bcnt} : 32'd0;
    assign w_cfg_wr = psel && penable && pwrite && paddr[2] == RegBucketCount;
    assign w_in_acc = in_ch.valid && in_ch.ready;

    always_comb begin
        if (r_bcnt == 9'd0) begin
            w_div = NW'(1);
        end else if ({23'd0, r_bcnt} > NUM_BUCKETS) begin
            w_div = NW'(NUM_BUCKETS);
        end else begin
            w_div = NW'(r_bcnt);
        end
    end

    assign w_prod = r_x * HashMul;
    assign w_mod.start = (r_state == t_st_fin);

    kfht_mod #(.DW(NW)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mod.start),
        .i_num  (r_x),
        .i_div  (w_div),
        .o_done (w_mod.done),
        .o_rem  (w_rem)
    );

    assign w_match  = (w_key == r_key);
    assign w_raddr  = {r_bkt, r_way[WW-1:0]};
    assign w_newcnt = r_hit ? ((w_count == 32'hffffffff) ? w_count : w_count + 32'd1) : 32'd1;
    assign w_waddr  = r_hit ? {r_bkt, r_hway} : {r_bkt, r_fill[WW-1:0]};
    assign w_we     = (r_state == t_st_upd) && r_cmd == CmdInsert &&
                      (r_hit || r_fill < FW'(WAYS));
    assign w_we_new = w_we && !r_hit;

    kfht_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_raddr (w_raddr),
        .i_we    (w_we),
        .i_we_new(w_we_new),
        .i_waddr (w_waddr),
        .i_wkey  (r_key),
        .i_wdata (r_dat),
        .i_wcount(w_newcnt),
        .o_key   (w_key),
        .o_data  (w_data),
        .o_count (w_count)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_st_clr:  if (r_clr == BW'(NUM_BUCKETS - 1)) n_state = t_st_idle;
            t_st_idle: if (w_in_acc) n_state = t_st_mix1;
            t_st_mix1: n_state = t_st_mul1;
            t_st_mul1: n_state = t_st_mix2;
            t_st_mix2: n_state = t_st_mul2;
            t_st_mul2: n_state = t_st_fin;
            t_st_fin:  n_state = t_st_mod;
            t_st_mod:  if (w_mod.done) n_state = t_st_fill;
            t_st_fill: n_state = t_st_rd;
            t_st_rd:   n_state = (r_fill == '0) ? t_st_upd : t_st_cmp;
            t_st_cmp: begin
                if (w_match || r_way + FW'(1) >= r_fill) begin
                    n_state = t_st_upd;
                end else begin
                    n_state = t_st_rd;
                end
            end
            t_st_upd:  n_state = t_st_out;
            t_st_out:  if (out_ch.ready) n_state = t_st_idle;
            default:   n_state = t_st_idle;
        endcase
    end

    always_comb begin
        in_ch.ready = (r_state == t_st_idle);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_st_clr;
            r_clr    <= '0;
            r_bcnt   <= BucketCountRst;
            r_uniq   <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == t_st_clr) r_clr <= r_clr + BW'(1);
            if (w_cfg_wr) r_bcnt <= pwdata[8:0];
            if (r_state == t_st_upd) begin
                r_ovalid <= 1'b1;
                if (w_we_new) begin
                    r_uniq <= r_uniq + 12'd1;
                    if (r_fill == '0) r_used <= r_used + 9'd1;
                end
            end else if (r_state == t_st_out && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_st_clr) begin
            r_fill_mem[r_clr] <= '0;
        end else if (r_state == t_st_upd && w_we_new) begin
            r_fill_mem[r_bkt] <= r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            t_st_idle: begin
                r_cmd <= in_ch.command;
                r_key <= in_ch.key;
                r_dat <= in_ch.data_value;
                r_x   <= xs16(in_ch.key);
            end
            t_st_mix1, t_st_mix2: r_x <= w_prod;
            t_st_mul1, t_st_mul2: r_x <= xs16(r_x);
            t_st_mod: begin
                if (w_mod.done) begin
                    r_bkt <= BW'(w_rem);
                end
            end
            t_st_fill: begin
                r_fill <= r_fill_mem[r_bkt];
                r_way  <= '0;
                r_hit  <= 1'b0;
            end
            t_st_cmp: begin
                if (w_match) begin
                    r_hit  <= 1'b1;
                    r_hway <= r_way[WW-1:0];
                    r_dout <= w_data;
                    r_cout <= w_count;
                end else begin
                    r_way <= r_way + FW'(1);
                end
            end
            t_st_upd: begin
                r_found <= r_hit;
                r_full  <= r_cmd == CmdInsert && !r_hit && r_fill >= FW'(WAYS);
                if (r_cmd == CmdLookup) begin
                    r_dout <= r_hit ? r_dout : 32'd0;
                    r_cout <= r_hit ? r_cout : 32'd0;
                end else begin
                    r_dout <= 32'd0;
                    r_cout <= (r_hit || r_fill < FW'(WAYS)) ?
                              (r_hit ? ((r_cout == 32'hffffffff) ? r_cout : r_cout + 32'd1)
                                     : 32'd1) : 32'd0;
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid        = r_ovalid;
    assign out_ch.found        = r_found;
    assign out_ch.data_out     = r_dout;
    assign out_ch.count_out    = r_cout;
    assign out_ch.bucket_full  = r_full;
    assign out_ch.unique_keys  = r_uniq;
    assign out_ch.buckets_used = r_used;

`ifndef SYNTHESIS
    a_valid_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == t_st_out) else $error("result valid outside output state");
    a_full_not_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_cmd == CmdLookup) |-> !r_full) else $error("full flag on lookup");
    a_uniq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != t_st_upd |=> r_uniq == $past(r_uniq)) else $error("key total moved");
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_found) |-> r_cout != 32'd0) else $error("hit with zero count");
`endif
endmodule
